// ===== rtl/core/srjs_pkg.sv =====
package srjs_pkg;

  localparam int NUM_LEGS       = 4;
  localparam int JOINTS_PER_LEG = 3;
  localparam int NUM_JOINTS     = NUM_LEGS * JOINTS_PER_LEG;
  localparam int ADDR_W         = $clog2(NUM_JOINTS);
  localparam int ANG_W          = 17;
  localparam int TGT_W          = 18;

  localparam logic [ANG_W-1:0] ANG_MAX     = 17'd46080;
  localparam logic [13:0]      ROLL_45     = 14'd11520;
  localparam logic [9:0]       FALL_SPEED  = 10'd160;
  localparam logic [15:0]      ACTIVATE_DT = 16'd5000;
  localparam logic [21:0]      SETTLE_US   = 22'd1000000;
  localparam logic [21:0]      TIMER_MAX   = 22'h3FFFFF;
  localparam logic [16:0]      RATE_FALL   = 17'd1600;
  localparam logic [16:0]      RATE_STILL  = 17'd160;
  localparam logic [16:0]      UPRIGHT     = 17'd2560;

  // step = round(|v| * dt / 1e6) = floor(((|v|*dt + 5e5) >> 6) / 15625)
  localparam logic [34:0] SLEW_HALF = 35'd500000;
  localparam logic [29:0] SLEW_REC  = 30'd562949953;  // floor(2^43 / 15625)
  localparam logic [13:0] SLEW_DIV  = 14'd15625;

  // knee = round(k * m * scale / 11520) = floor(((..) + 5760) >> 8) / 45
  localparam logic [12:0] KNEE_HALF  = 13'd5760;
  localparam logic [21:0] KNEE_REC   = 22'd2982616;  // floor(2^27 / 45)
  localparam logic [5:0]  KNEE_DIV   = 6'd45;
  localparam logic [5:0]  KNEE_PRESS = 6'd35;
  localparam logic [5:0]  KNEE_FREE  = 6'd3;

  typedef enum logic [2:0] {
    REG_TICK,
    REG_GAIN,
    REG_MAXSPD,
    REG_KSCALE,
    REG_SAFE_HIP,
    REG_SAFE_THIGH,
    REG_SAFE_KNEE
  } cfg_reg_t;

  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] addr;
    logic [TGT_W-1:0]  tgt;
    logic              set;
  } srjs_req_t;

  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] addr;
    logic [ANG_W-1:0]  data;
    logic              reach;
  } srjs_wr_t;

  function automatic logic [TGT_W-1:0] deg_fix(input logic signed [8:0] d);
    deg_fix = {d[8], d, 8'b0};
  endfunction

  // hip and thigh of the safe poses
  function automatic logic signed [8:0] safe_pose(input logic is_free, input logic j);
    case ({is_free, j})
      2'b00:   safe_pose = 9'sd120;
      2'b01:   safe_pose = 9'sd45;
      2'b10:   safe_pose = 9'sd60;
      default: safe_pose = 9'sd110;
    endcase
  endfunction

  function automatic logic signed [8:0] stage_pose(input logic [1:0] st,
                                                   input logic is_free,
                                                   input logic [1:0] j);
    case ({st, is_free, j})
      5'b00_0_00: stage_pose = 9'sd120;
      5'b00_0_01: stage_pose = 9'sd110;
      5'b00_0_10: stage_pose = -9'sd35;
      5'b00_1_00: stage_pose = 9'sd60;
      5'b00_1_01: stage_pose = 9'sd110;
      5'b00_1_10: stage_pose = -9'sd3;
      5'b01_0_00: stage_pose = 9'sd120;
      5'b01_0_01: stage_pose = 9'sd110;
      5'b01_0_10: stage_pose = 9'sd0;
      5'b01_1_00: stage_pose = 9'sd90;
      5'b01_1_01: stage_pose = 9'sd50;
      5'b01_1_10: stage_pose = -9'sd3;
      5'b10_0_00: stage_pose = 9'sd120;
      5'b10_0_01: stage_pose = 9'sd90;
      5'b10_0_10: stage_pose = 9'sd0;
      5'b10_1_00: stage_pose = 9'sd120;
      5'b10_1_01: stage_pose = 9'sd35;
      5'b10_1_10: stage_pose = -9'sd3;
      5'b11_0_00: stage_pose = 9'sd130;
      5'b11_0_01: stage_pose = 9'sd35;
      5'b11_0_10: stage_pose = -9'sd3;
      5'b11_1_00: stage_pose = 9'sd130;
      5'b11_1_01: stage_pose = 9'sd35;
      5'b11_1_10: stage_pose = -9'sd3;
      default:    stage_pose = 9'sd0;
    endcase
  endfunction

endpackage

// ===== rtl/core/srjs_ram.sv =====
module srjs_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/srjs_slew.sv =====
module srjs_slew import srjs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  srjs_req_t        req,
  input  logic [ANG_W-1:0] rd_data,
  input  logic [9:0]       gain,
  input  logic [9:0]       lim,
  input  logic [15:0]      dt,
  output srjs_wr_t         wr,
  output logic             busy
);

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TGT_W-1:0]  tgt;
    logic              set;
    logic [ANG_W-1:0]  now;
    logic              reach;
    logic              neg;
  } ctx_t;

  logic [6:1] vld_r;
  ctx_t       c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;

  logic signed [29:0] v2_r;
  logic [33:0]        prod3_r;
  logic [28:0]        y4_r, y5_r;
  logic [15:0]        qe5_r, q6_r;

  logic signed [18:0] err1;
  logic signed [29:0] v1;
  logic signed [29:0] lim256;
  logic [17:0]        mag2;
  logic               neg2;
  logic [34:0]        ysum3;
  logic [58:0]        qprod4;
  logic [29:0]        rem5;
  logic [15:0]        q5;
  logic signed [18:0] sum6;
  logic signed [18:0] res6;
  logic [ANG_W-1:0]   sat6;

  always_comb begin
    err1 = $signed({c1_r.tgt[TGT_W-1], c1_r.tgt})
         - $signed({{2{rd_data[ANG_W-1]}}, rd_data});
    v1   = err1 * $signed({1'b0, gain});
  end

  always_comb begin
    lim256 = $signed({12'b0, lim, 8'b0});
    neg2   = v2_r[29];
    if (v2_r > lim256 || v2_r < -lim256) begin
      mag2 = lim256[17:0];
    end else if (neg2) begin
      mag2 = 18'(-v2_r);
    end else begin
      mag2 = v2_r[17:0];
    end
  end

  always_comb begin
    ysum3  = 35'(prod3_r) + SLEW_HALF;
    qprod4 = 59'(y4_r) * 59'(SLEW_REC);
    rem5   = 30'(y5_r) - 30'(qe5_r) * 30'(SLEW_DIV);
    q5     = (rem5 >= 30'(SLEW_DIV)) ? qe5_r + 16'd1 : qe5_r;
  end

  always_comb begin
    sum6 = $signed({{2{c6_r.now[ANG_W-1]}}, c6_r.now})
         + (c6_r.neg ? -$signed({3'b0, q6_r}) : $signed({3'b0, q6_r}));
    res6 = c6_r.set ? $signed({c6_r.tgt[TGT_W-1], c6_r.tgt}) : sum6;
    if (res6 > $signed({2'b0, ANG_MAX})) begin
      sat6 = ANG_MAX;
    end else if (res6 < -$signed({2'b0, ANG_MAX})) begin
      sat6 = 17'(-$signed({2'b0, ANG_MAX}));
    end else begin
      sat6 = res6[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:1], req.vld};
    end
    c1_r      <= '{addr: req.addr, tgt: req.tgt, set: req.set, now: '0,
                   reach: 1'b0, neg: 1'b0};
    c2_r      <= '{addr: c1_r.addr, tgt: c1_r.tgt, set: c1_r.set, now: rd_data,
                   reach: (err1 < 19'sd128) && (err1 > -19'sd128), neg: 1'b0};
    v2_r      <= v1;
    c3_r      <= '{addr: c2_r.addr, tgt: c2_r.tgt, set: c2_r.set, now: c2_r.now,
                   reach: c2_r.reach, neg: neg2};
    prod3_r   <= 34'(mag2) * 34'(dt);
    c4_r      <= c3_r;
    y4_r      <= ysum3[34:6];
    c5_r      <= c4_r;
    y5_r      <= y4_r;
    qe5_r     <= qprod4[58:43];
    c6_r      <= c5_r;
    q6_r      <= q5;
  end

  assign wr.vld   = vld_r[6];
  assign wr.addr  = c6_r.addr;
  assign wr.data  = sat6;
  assign wr.reach = c6_r.reach;
  assign busy     = |vld_r;

endmodule

// ===== rtl/core/self_righting_joint_sequencer_core.sv =====
// Self-righting joint sequencer.
// Input channel (in_valid/in_stall): one transaction per control tick or
// activate request. Result channel (out_valid/out_stall): twelve joint
// transactions per input, leg 0..3 and joint 0..2 within a leg, the twelfth
// flagged by out_last. stage and fallen show the state after the step.
// Configuration goes through the APB port; pready is tied high.
// Steps: an input runs the knee setup (two reciprocal divides), then issues
// the joints into the 6-stage slew pipeline and waits for it to drain, then
// an update step, then reads each result through the single read port of
// the angle memory. A step in the final stage skips the slew pass. in_stall
// is high from acceptance until the twelfth result sits in the output
// register, so the next input can be taken while that result still waits.
// A stalled result holds in the output register and the sequencer waits.
// Reset clears the stage, timer, flags, configuration to its defaults and
// the per-joint valid bits, so all angles read as zero.
module self_righting_joint_sequencer_core import srjs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_func,
  input  logic signed [16:0]      in_roll_angle,
  input  logic signed [16:0]      in_roll_ctrl_angle,
  input  logic signed [15:0]      in_roll_rate,
  input  logic                    in_recover_mode,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_leg_index,
  output logic [1:0]              out_joint_index,
  output logic signed [16:0]      out_joint_angle,
  output logic [2:0]              out_stage,
  output logic                    out_fallen,
  output logic                    out_last,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [4:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_KMS, ST_KY, ST_KMUL, ST_KFIX, ST_SLEW, ST_DRAIN, ST_UPD,
    ST_ERD, ST_EWR
  } state_t;

  state_t state_r;

  logic [15:0]       tick_r;
  logic [9:0]        gain_r, maxspd_r, kscale_r;
  logic [16:0]       safe_hip_r, safe_thigh_r, safe_knee_r;

  logic              func_r, recov_r;
  logic signed [16:0] roll_r, ctrl_r;
  logic signed [15:0] rate_r;

  logic [2:0]        stage_r;
  logic [21:0]       timer_r;
  logic              psf_r, fallen_r, all_r;

  logic [23:0]       ms_r;
  logic [20:0]       ky_r;
  logic [15:0]       kq_r;
  logic              ksel_r;
  logic [TGT_W-1:0]  kp_r, kf_r;

  logic [1:0]        leg_r, jnt_r;
  logic [NUM_JOINTS-1:0] jvld_r;
  logic              rdv_r;

  logic              out_valid_r, out_fallen_r, out_last_r;
  logic [1:0]        out_leg_r, out_jnt_r;
  logic [ANG_W-1:0]  out_ang_r;
  logic [2:0]        out_stage_r;

  logic [ADDR_W-1:0] addr;
  logic [ANG_W-1:0]  rdata, rd_m;
  srjs_req_t         req;
  srjs_wr_t          wr;
  logic              busy;

  logic              fall_mode, safe_mode, move_mode;
  logic signed [16:0] ksrc;
  logic [16:0]       kabs;
  logic [13:0]       km;
  logic [29:0]       kprod;
  logic [47:0]       kmul;
  logic [21:0]       krem;
  logic [15:0]       kq;
  logic [9:0]        lim;
  logic [15:0]       dt;
  logic              front, is_free;
  logic [TGT_W-1:0]  hip_thigh, tgt_press, tgt_free;
  logic [16:0]       rabs, cabs;
  logic [22:0]       tsum;
  logic [21:0]       tsat;
  logic              accept, out_free;

  assign addr      = ADDR_W'({leg_r, 1'b0}) + ADDR_W'(leg_r) + ADDR_W'(jnt_r);
  assign rd_m      = rdv_r ? rdata : '0;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign pready    = 1'b1;

  assign fall_mode = func_r || (stage_r == 3'd0);
  assign safe_mode = !func_r && (stage_r == 3'd1);
  assign move_mode = !func_r && (stage_r >= 3'd2) && (stage_r <= 3'd6);

  always_comb begin
    ksrc  = safe_mode ? roll_r : ctrl_r;
    kabs  = ksrc[16] ? 17'(-ksrc) : 17'(ksrc);
    km    = (kabs > 17'(ROLL_45)) ? ROLL_45 : kabs[13:0];
    kprod = 30'(ms_r) * 30'(ksel_r ? KNEE_FREE : KNEE_PRESS) + 30'(KNEE_HALF);
    kmul  = 48'(ky_r) * 48'(KNEE_REC);
    krem  = 22'(ky_r) - 22'(kq_r) * 22'(KNEE_DIV);
    kq    = (krem >= 22'(KNEE_DIV)) ? kq_r + 16'd1 : kq_r;
  end

  always_comb begin
    lim       = fall_mode ? FALL_SPEED : maxspd_r;
    dt        = func_r ? ACTIVATE_DT : tick_r;
    front     = !leg_r[1];
    hip_thigh = '0;
    tgt_press = (jnt_r == 2'd2) ? kp_r : deg_fix(safe_pose(1'b0, jnt_r[0]));
    tgt_free  = (jnt_r == 2'd2) ? kf_r : deg_fix(safe_pose(1'b1, jnt_r[0]));
    req.vld   = (state_r == ST_SLEW);
    req.addr  = addr;
    req.tgt   = tgt_press;
    req.set   = 1'b1;
    is_free   = 1'b0;
    if (fall_mode) begin
      is_free  = ctrl_r[16] ? front : !front;
      req.tgt  = is_free ? tgt_free : tgt_press;
      req.set  = !is_free;
    end else if (safe_mode) begin
      is_free  = (front == roll_r[16]);
      req.tgt  = is_free ? tgt_free : tgt_press;
    end else begin
      is_free  = (front != psf_r);
      hip_thigh = deg_fix(stage_pose(2'(stage_r - 3'd2), is_free, jnt_r));
      req.set  = 1'b0;
      if (stage_r == 3'd6) begin
        case (jnt_r)
          2'd0:    req.tgt = {safe_hip_r[16], safe_hip_r};
          2'd1:    req.tgt = {safe_thigh_r[16], safe_thigh_r};
          default: req.tgt = {safe_knee_r[16], safe_knee_r};
        endcase
      end else begin
        req.tgt = hip_thigh;
      end
    end
  end

  always_comb begin
    rabs = rate_r[15] ? 17'(-rate_r) : 17'(rate_r);
    cabs = ctrl_r[16] ? 17'(-ctrl_r) : 17'(ctrl_r);
    tsum = 23'(timer_r) + 23'(tick_r);
    tsat = (tsum > 23'(TIMER_MAX)) ? TIMER_MAX : tsum[21:0];
  end

  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      REG_TICK:       prdata = 32'(tick_r);
      REG_GAIN:       prdata = 32'(gain_r);
      REG_MAXSPD:     prdata = 32'(maxspd_r);
      REG_KSCALE:     prdata = 32'(kscale_r);
      REG_SAFE_HIP:   prdata = {{15{safe_hip_r[16]}}, safe_hip_r};
      REG_SAFE_THIGH: prdata = {{15{safe_thigh_r[16]}}, safe_thigh_r};
      REG_SAFE_KNEE:  prdata = {{15{safe_knee_r[16]}}, safe_knee_r};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r       <= 16'd5000;
      gain_r       <= 10'd100;
      maxspd_r     <= 10'd66;
      kscale_r     <= 10'd384;
      safe_hip_r   <= '0;
      safe_thigh_r <= '0;
      safe_knee_r  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_TICK:       tick_r       <= pwdata[15:0];
        REG_GAIN:       gain_r       <= pwdata[9:0];
        REG_MAXSPD:     maxspd_r     <= pwdata[9:0];
        REG_KSCALE:     kscale_r     <= pwdata[9:0];
        REG_SAFE_HIP:   safe_hip_r   <= pwdata[16:0];
        REG_SAFE_THIGH: safe_thigh_r <= pwdata[16:0];
        REG_SAFE_KNEE:  safe_knee_r  <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jvld_r <= '0;
    end else if (wr.vld) begin
      jvld_r[wr.addr] <= 1'b1;
    end
    rdv_r <= jvld_r[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stage_r     <= '0;
      timer_r     <= '0;
      psf_r       <= 1'b0;
      fallen_r    <= 1'b0;
      all_r       <= 1'b1;
      ksel_r      <= 1'b0;
      leg_r       <= '0;
      jnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (wr.vld && !wr.reach) begin
        all_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_KMS;
            ksel_r  <= 1'b0;
          end
        end
        ST_KMS: begin
          state_r <= ST_KY;
        end
        ST_KY: begin
          state_r <= ST_KMUL;
        end
        ST_KMUL: begin
          state_r <= ST_KFIX;
        end
        ST_KFIX: begin
          if (!ksel_r) begin
            ksel_r  <= 1'b1;
            state_r <= ST_KY;
          end else begin
            leg_r   <= '0;
            jnt_r   <= '0;
            all_r   <= 1'b1;
            state_r <= (fall_mode || safe_mode || move_mode) ? ST_SLEW : ST_UPD;
          end
        end
        ST_SLEW: begin
          if (jnt_r == 2'd2) begin
            jnt_r <= '0;
            leg_r <= leg_r + 2'd1;
            if (leg_r == 2'd3) begin
              state_r <= ST_DRAIN;
            end
          end else begin
            jnt_r <= jnt_r + 2'd1;
          end
        end
        ST_DRAIN: begin
          if (!busy) begin
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          state_r <= ST_ERD;
          if (func_r) begin
            fallen_r <= 1'b1;
            timer_r  <= '0;
            stage_r  <= '0;
          end else if (stage_r == 3'd0 || stage_r == 3'd1) begin
            if ((stage_r == 3'd0) ? (rabs < RATE_FALL && recov_r) : (rabs < RATE_STILL)) begin
              if (tsat > SETTLE_US) begin
                timer_r <= '0;
                stage_r <= stage_r + 3'd1;
                if (stage_r == 3'd1) begin
                  psf_r <= (ctrl_r > 17'sd0);
                end
              end else begin
                timer_r <= tsat;
              end
            end else begin
              timer_r <= '0;
            end
          end else if (move_mode && all_r) begin
            if (stage_r != 3'd6) begin
              stage_r <= stage_r + 3'd1;
            end else if (cabs < UPRIGHT) begin
              fallen_r <= 1'b0;
              stage_r  <= 3'd7;
            end
          end
        end
        ST_ERD: begin
          if (out_free) begin
            state_r <= ST_EWR;
          end
        end
        ST_EWR: begin
          out_valid_r <= 1'b1;
          out_last_r  <= (leg_r == 2'd3) && (jnt_r == 2'd2);
          if (jnt_r == 2'd2) begin
            jnt_r <= '0;
            leg_r <= leg_r + 2'd1;
            state_r <= (leg_r == 2'd3) ? ST_IDLE : ST_ERD;
          end else begin
            jnt_r   <= jnt_r + 2'd1;
            state_r <= ST_ERD;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
    if (accept) begin
      func_r  <= in_func;
      roll_r  <= in_roll_angle;
      ctrl_r  <= in_roll_ctrl_angle;
      rate_r  <= in_roll_rate;
      recov_r <= in_recover_mode;
    end
    if (state_r == ST_KMS) begin
      ms_r <= 24'(km) * 24'(kscale_r);
    end
    if (state_r == ST_KY) begin
      ky_r <= kprod[28:8];
    end
    if (state_r == ST_KMUL) begin
      kq_r <= kmul[42:27];
    end
    if (state_r == ST_KFIX) begin
      if (ksel_r) begin
        kf_r <= 18'(0) - 18'(kq);
      end else begin
        kp_r <= 18'(0) - 18'(kq);
      end
    end
    if (state_r == ST_EWR) begin
      out_leg_r   <= leg_r;
      out_jnt_r   <= jnt_r;
      out_ang_r   <= rd_m;
      out_stage_r <= stage_r;
      out_fallen_r <= fallen_r;
    end
  end

  srjs_ram #(
    .WIDTH (ANG_W),
    .DEPTH (NUM_JOINTS)
  ) u_ram (
    .clk   (clk),
    .we    (wr.vld),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (addr),
    .rdata (rdata)
  );

  srjs_slew u_slew (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_m),
    .gain    (gain_r),
    .lim     (lim),
    .dt      (dt),
    .wr      (wr),
    .busy    (busy)
  );

  assign out_valid       = out_valid_r;
  assign out_leg_index   = out_leg_r;
  assign out_joint_index = out_jnt_r;
  assign out_joint_angle = out_ang_r;
  assign out_stage       = out_stage_r;
  assign out_fallen      = out_fallen_r;
  assign out_last        = out_last_r;

endmodule

// ===== rtl/core/srjs_chk.sv =====
module srjs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_leg_index,
  input logic [1:0]  out_joint_index,
  input logic [16:0] out_joint_angle,
  input logic [2:0]  out_stage,
  input logic        out_fallen,
  input logic        out_last
);

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_leg_index == 2'd3 && out_joint_index == 2'd2)
    else $error("last flag on wrong joint");

  a_joint_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_joint_index != 2'd3)
    else $error("joint index out of range");

  a_done_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stage == 3'd7 |-> !out_fallen)
    else $error("done stage while fallen");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("not busy after input transaction");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_joint_angle) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind self_righting_joint_sequencer_core srjs_chk u_srjs_chk (.*);
